// ===== rtl/core/cdq_pkg.sv =====
// Package for the circular deque: widths, codes and item types.
package cdq_pkg;

  localparam int CAP_W     = 5;   // capacity and occupancy counters
  localparam int CAP_MAX   = 16;  // most elements one read-out may return
  localparam int CMD_W     = 3;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_READ_ALL   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_OUT   = 2'd2
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } rsp_t;

endpackage

// ===== rtl/core/circular_deque.sv =====
// Circular deque top level: ring store, pointers, command sequencer and result register.
//
// Double-ended queue of signed 32-bit words kept in a ring of capacity
// cfg_wdata slots (saturated to 1..min(DEPTH,16); a write also empties the
// deque, store contents are kept). Commands on req: push front/rear, pop
// front/rear, read out all. Each push or pop gives one rsp item; a read-out
// gives one item per stored element, front to rear, with last set on the
// final one, or a single EMPTY item when there is nothing stored. Codes 5..7
// are taken and dropped with no item. One command is handled at a time and
// req_ready is high only while idle. With rsp_ready held high, a push or a
// failed command passes accept and present, a successful pop accept, store
// read and present, and a read-out accept, then store read and present per
// element. These steps come from the single store read port with a
// registered output, and from the one shared index step unit that advances
// head, tail and the read-out pointer. There is no clearing pass after reset.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] CapLimit = CAP_W'((DEPTH < CAP_MAX) ? DEPTH : CAP_MAX);

  // ring store, single write port, registered read
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;

  state_t state, state_next;

  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [IW-1:0]    ptr;      // read-out position
  logic [CAP_W-1:0] occ;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] sent;     // read-out items issued so far
  logic             scan;     // a read-out is in progress
  rsp_t             rsp_q;

  logic             req_fire;
  logic             rsp_fire;
  logic             scan_more;
  logic             is_push;
  logic             is_pop;
  logic             is_read;
  logic             use_tail;
  logic             full;
  logic             empty;
  logic [CAP_W-1:0] cap_sat;

  logic [IW-1:0]    step_idx;
  logic             step_dec;
  logic [IW-1:0]    step_nxt;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = rsp_q;

  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;
  assign scan_more = rsp_fire && scan && !rsp_q.last;

  assign is_push  = (req.cmd == CMD_PUSH_FRONT) || (req.cmd == CMD_PUSH_REAR);
  assign is_pop   = (req.cmd == CMD_POP_FRONT) || (req.cmd == CMD_POP_REAR);
  assign is_read  = (req.cmd == CMD_READ_ALL);
  assign use_tail = (req.cmd == CMD_PUSH_REAR) || (req.cmd == CMD_POP_REAR);
  assign full     = (occ >= cap);
  assign empty    = (occ == '0);

  // capacity write saturates into 1..CapLimit
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_sat = CAP_W'(1);
    end else if (cfg_wdata > CapLimit) begin
      cap_sat = CapLimit;
    end else begin
      cap_sat = cfg_wdata;
    end
  end

  // shared step unit: head/tail while idle, read-out pointer otherwise
  always_comb begin
    if (state == S_IDLE) begin
      step_idx = use_tail ? tail : head;
      step_dec = (req.cmd == CMD_PUSH_FRONT) || (req.cmd == CMD_POP_REAR);
    end else begin
      step_idx = ptr;
      step_dec = 1'b0;
    end
  end

  cdq_ring_step #(
    .IW (IW)
  ) u_step (
    .idx (step_idx),
    .dec (step_dec),
    .cap (cap),
    .nxt (step_nxt)
  );

  // store ports; a push on an empty deque lands in slot 0
  assign wr_en   = req_fire && is_push && !full;
  assign wr_addr = empty ? '0 : step_nxt;
  assign rd_en   = (req_fire && (is_pop || is_read) && !empty) || scan_more;
  assign rd_addr = (state == S_IDLE) ? step_idx : ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.push_value;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (is_push) begin
            state_next = S_OUT;
          end else if (is_pop || is_read) begin
            state_next = empty ? S_OUT : S_FETCH;
          end
        end
      end
      S_FETCH: state_next = S_OUT;
      S_OUT: begin
        if (rsp_fire) begin
          state_next = scan_more ? S_FETCH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pointers, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      ptr  <= '0;
      occ  <= '0;
      cap  <= CapLimit;
      sent <= '0;
      scan <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap  <= cap_sat;
        head <= '0;
        tail <= '0;
        occ  <= '0;
      end
      if (req_fire) begin
        rsp_q.data <= '0;
        rsp_q.last <= 1'b1;
        scan       <= 1'b0;
        if (is_push) begin
          if (full) begin
            rsp_q.status <= ST_OVERFLOW;
          end else begin
            rsp_q.status <= ST_OK;
            occ          <= occ + CAP_W'(1);
            if (empty) begin
              head <= '0;
              tail <= '0;
            end else if (use_tail) begin
              tail <= step_nxt;
            end else begin
              head <= step_nxt;
            end
          end
        end else if (is_pop) begin
          if (empty) begin
            rsp_q.status <= ST_UNDERFLOW;
          end else begin
            rsp_q.status <= ST_OK;
            occ          <= occ - CAP_W'(1);
            if (occ == CAP_W'(1)) begin
              head <= '0;
              tail <= '0;
            end else if (use_tail) begin
              tail <= step_nxt;
            end else begin
              head <= step_nxt;
            end
          end
        end else if (is_read) begin
          if (empty) begin
            rsp_q.status <= ST_EMPTY;
          end else begin
            rsp_q.status <= ST_OK;
            scan         <= 1'b1;
            ptr          <= step_nxt;
            sent         <= CAP_W'(1);
          end
        end
      end
      if (state == S_FETCH) begin
        rsp_q.data <= mem_q;
        rsp_q.last <= !scan || (sent == occ);
      end
      if (scan_more) begin
        ptr  <= step_nxt;
        sent <= sent + CAP_W'(1);
      end
    end
  end

  // occupancy never passes the capacity in use
  a_occ_cap: assert property (@(posedge clk) disable iff (rst) occ <= cap)
    else $error("occupancy above capacity");

  // stored elements sit inside the ring in use
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((CAP_W + IW)'(head) < (CAP_W + IW)'(cap))
            && ((CAP_W + IW)'(tail) < (CAP_W + IW)'(cap)))
    else $error("head or tail outside ring");

  // a successful pop removes exactly one element
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    req_fire && is_pop && !empty && !cfg_we |=> occ == $past(occ) - CAP_W'(1))
    else $error("pop did not decrement occupancy");

  // the final read-out item comes once every stored element has been sent
  a_scan_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && scan && rsp_q.last |-> sent == occ)
    else $error("read-out ended early");

endmodule

// ===== rtl/core/cdq_ring_step.sv =====
// Ring index step unit: moves a slot index one place up or down, wrapping at the capacity.
module cdq_ring_step
  import cdq_pkg::*;
#(
  parameter int IW = 4
) (
  input  logic [IW-1:0]    idx,
  input  logic             dec,
  input  logic [CAP_W-1:0] cap,
  output logic [IW-1:0]    nxt
);

  localparam int SW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  logic [SW-1:0] idx_x;
  logic [SW-1:0] cap_x;
  logic [SW-1:0] inc;
  logic [SW-1:0] cap_m1;

  always_comb begin
    idx_x  = SW'(idx);
    cap_x  = SW'(cap);
    inc    = idx_x + SW'(1);
    cap_m1 = cap_x - SW'(1);
    if (dec) begin
      nxt = (idx == '0) ? cap_m1[IW-1:0] : idx - IW'(1);
    end else begin
      nxt = (inc >= cap_x) ? '0 : inc[IW-1:0];
    end
  end

endmodule
